@@ hdl/lru_cache_miss_counter_unit_assert.svh @@
// Assertion shorthands for the LRU miss counter; clock and reset come from the including module.
`ifndef LRU_CACHE_MISS_COUNTER_UNIT_ASSERT_SVH
`define LRU_CACHE_MISS_COUNTER_UNIT_ASSERT_SVH

// Same-cycle implication.
`define LCMC_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define LCMC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hdl/lcmc_pkg.sv @@
package lcmc_pkg;

   // default geometry
   localparam int LCMC_DEPTH     = 16;
   localparam int LCMC_KEY_WIDTH = 32;

   // fixed field widths
   localparam int ACCESS_KEY_WIDTH = 32;
   localparam int OCCUPANCY_WIDTH  = 5;
   localparam int MISS_COUNT_WIDTH = 32;
   localparam int CAPACITY_WIDTH   = 5;

   localparam logic [CAPACITY_WIDTH-1:0]   CAPACITY_RESET = CAPACITY_WIDTH'(16);
   localparam logic [MISS_COUNT_WIDTH-1:0] MISS_MAX       = '1;

endpackage

@@ hdl/lcmc_req_if.sv @@
interface lcmc_req_if;
   import lcmc_pkg::*;

   logic                               valid;
   logic                               ready;
   logic signed [ACCESS_KEY_WIDTH-1:0] access_key;

   modport source (output valid, output access_key, input ready);
   modport sink   (input valid, input access_key, output ready);
endinterface

@@ hdl/lcmc_rsp_if.sv @@
interface lcmc_rsp_if;
   import lcmc_pkg::*;

   logic                               valid;
   logic                               ready;
   logic                               hit;
   logic                               evicted;
   logic signed [ACCESS_KEY_WIDTH-1:0] evicted_key;
   logic [OCCUPANCY_WIDTH-1:0]         occupancy;
   logic [MISS_COUNT_WIDTH-1:0]        miss_count;

   modport source (output valid, output hit, output evicted, output evicted_key,
                   output occupancy, output miss_count, input ready);
   modport sink   (input valid, input hit, input evicted, input evicted_key,
                   input occupancy, input miss_count, output ready);
endinterface

@@ hdl/lru_cache_miss_counter_unit.sv @@
// One item is in work at a time: a new one is taken only after the last is written back;
// the scan reads the resident keys through the single key memory, one entry per cycle.
// A waiting result does not block taking or scanning the next item, only its write-back.
// Reset (synchronous, active high) clears occupancy, miss count, ring head and capacity
// (to 16); the key memory keeps its contents and needs no clearing pass.
`include "lru_cache_miss_counter_unit_assert.svh"

module lru_cache_miss_counter_unit #(
   parameter int DEPTH     = lcmc_pkg::LCMC_DEPTH,
   parameter int KEY_WIDTH = lcmc_pkg::LCMC_KEY_WIDTH
) (
   input  logic                                clock,
   input  logic                                reset,
   lcmc_req_if.sink                            req_ch,
   lcmc_rsp_if.source                          rsp_ch,
   input  logic                                csr_wr_en,
   input  logic [lcmc_pkg::CAPACITY_WIDTH-1:0] csr_wr_data
);
   import lcmc_pkg::*;

   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int SUM_W  = CNT_W + 1;

   // The keys sit in a ring: logical entry 0 (least recent) lives at slot head_ff,
   // entry i at slot head_ff + i, wrapped. Eviction then only advances the head; a hit
   // closes the gap by copying each later entry one place down during the scan.
   typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_FINISH} state_type;

   // Map a logical position to a memory slot. The sum stays below 2*DEPTH, so one
   // compare and subtract wraps it.
   function automatic logic [ADDR_W-1:0] slot_of(input logic [ADDR_W-1:0] head,
                                                 input logic [CNT_W-1:0]  idx);
      logic [SUM_W-1:0] sum;
      sum = SUM_W'(head) + SUM_W'(idx);
      if (sum >= SUM_W'(DEPTH)) begin
         sum = sum - SUM_W'(DEPTH);
      end
      return sum[ADDR_W-1:0];
   endfunction

   // key memory, one read and one write port, registered read data
   logic [KEY_WIDTH-1:0] key_mem [DEPTH];
   logic [KEY_WIDTH-1:0] rd_data_ff;
   logic                 rd_en;
   logic [ADDR_W-1:0]    rd_addr;
   logic                 wr_en;
   logic [ADDR_W-1:0]    wr_addr;
   logic [KEY_WIDTH-1:0] wr_data;

   // control state
   state_type                   state_ff, state_in;
   logic [CNT_W-1:0]            scan_idx_ff, scan_idx_in;
   logic                        pend_ff, pend_in;
   logic [CNT_W-1:0]            pend_idx_ff, pend_idx_in;
   logic                        found_ff, found_in;
   logic [KEY_WIDTH-1:0]        key_ff, key_in;
   logic [KEY_WIDTH-1:0]        ev_key_ff, ev_key_in;
   logic [ADDR_W-1:0]           head_ff, head_in;
   logic [CNT_W-1:0]            count_ff, count_in;
   logic [MISS_COUNT_WIDTH-1:0] misses_ff, misses_in;
   logic [CAPACITY_WIDTH-1:0]   capacity_ff, capacity_in;

   // result register
   logic                        rsp_valid_ff, rsp_valid_in;
   logic                        rsp_hit_ff, rsp_hit_in;
   logic                        rsp_evicted_ff, rsp_evicted_in;
   logic [ACCESS_KEY_WIDTH-1:0] rsp_ev_key_ff, rsp_ev_key_in;
   logic [OCCUPANCY_WIDTH-1:0]  rsp_occ_ff, rsp_occ_in;
   logic [MISS_COUNT_WIDTH-1:0] rsp_misses_ff, rsp_misses_in;

   logic [CNT_W-1:0] eff_cap;
   logic [63:0]      in_wide;
   logic [63:0]      ev_wide;
   logic [31:0]      occ_wide;
   logic             load;
   logic             miss;
   logic             evict;

   assign req_ch.ready       = (state_ff == ST_IDLE);
   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.hit         = rsp_hit_ff;
   assign rsp_ch.evicted     = rsp_evicted_ff;
   assign rsp_ch.evicted_key = signed'(rsp_ev_key_ff);
   assign rsp_ch.occupancy   = rsp_occ_ff;
   assign rsp_ch.miss_count  = rsp_misses_ff;

   // Keys are kept in their low KEY_WIDTH bits, taken from the zero-extended field.
   assign in_wide = {32'b0, req_ch.access_key};
   assign ev_wide = 64'(ev_key_ff);

   // Clamp capacity: zero counts as one, anything above DEPTH as DEPTH.
   always_comb begin
      if (capacity_ff == '0) begin
         eff_cap = CNT_W'(1);
      end else if (32'(capacity_ff) > DEPTH) begin
         eff_cap = CNT_W'(DEPTH);
      end else begin
         eff_cap = CNT_W'(capacity_ff);
      end
   end

   assign load  = !rsp_valid_ff || rsp_ch.ready;
   assign miss  = !found_ff;
   assign evict = miss && (count_ff >= eff_cap);

   always_comb begin
      state_in       = state_ff;
      scan_idx_in    = scan_idx_ff;
      pend_in        = 1'b0;
      pend_idx_in    = pend_idx_ff;
      found_in       = found_ff;
      key_in         = key_ff;
      ev_key_in      = ev_key_ff;
      head_in        = head_ff;
      count_in       = count_ff;
      misses_in      = misses_ff;
      capacity_in    = csr_wr_en ? csr_wr_data : capacity_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ch.ready;
      rsp_hit_in     = rsp_hit_ff;
      rsp_evicted_in = rsp_evicted_ff;
      rsp_ev_key_in  = rsp_ev_key_ff;
      rsp_occ_in     = rsp_occ_ff;
      rsp_misses_in  = rsp_misses_ff;
      rd_en          = 1'b0;
      rd_addr        = slot_of(head_ff, scan_idx_ff);
      wr_en          = 1'b0;
      wr_addr        = slot_of(head_ff, pend_idx_ff - CNT_W'(1));
      wr_data        = rd_data_ff;
      occ_wide       = 32'(count_ff);

      unique case (state_ff)
         ST_IDLE: begin
            // take the next key and start the scan at the least-recent end
            if (req_ch.valid) begin
               key_in      = in_wide[KEY_WIDTH-1:0];
               found_in    = 1'b0;
               scan_idx_in = '0;
               state_in    = ST_SCAN;
            end
         end
         ST_SCAN: begin
            // issue one read a cycle while entries remain
            if (scan_idx_ff != count_ff) begin
               rd_en       = 1'b1;
               scan_idx_in = scan_idx_ff + CNT_W'(1);
               pend_in     = 1'b1;
               pend_idx_in = scan_idx_ff;
            end else begin
               state_in = ST_FINISH;
            end
            // examine the entry read last cycle
            if (pend_ff) begin
               if (found_ff) begin
                  // behind the hit: shift one place toward the least-recent end
                  wr_en = 1'b1;
               end else if (rd_data_ff == key_ff) begin
                  found_in = 1'b1;
               end
               if (pend_idx_ff == '0) begin
                  ev_key_in = rd_data_ff;
               end
            end
         end
         ST_FINISH: begin
            // hold until the result register is free, then write back and report
            if (load) begin
               wr_en   = 1'b1;
               wr_data = key_ff;
               wr_addr = found_ff ? slot_of(head_ff, count_ff - CNT_W'(1))
                                  : slot_of(head_ff, count_ff);
               if (evict) begin
                  head_in = slot_of(head_ff, CNT_W'(1));
               end else if (miss) begin
                  count_in = count_ff + CNT_W'(1);
               end
               if (miss && (misses_ff != MISS_MAX)) begin
                  misses_in = misses_ff + MISS_COUNT_WIDTH'(1);
               end
               occ_wide       = 32'(count_in);
               rsp_valid_in   = 1'b1;
               rsp_hit_in     = found_ff;
               rsp_evicted_in = evict;
               rsp_ev_key_in  = evict ? ev_wide[ACCESS_KEY_WIDTH-1:0] : '0;
               rsp_occ_in     = occ_wide[OCCUPANCY_WIDTH-1:0];
               rsp_misses_in  = misses_in;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         scan_idx_ff  <= '0;
         pend_ff      <= 1'b0;
         found_ff     <= 1'b0;
         head_ff      <= '0;
         count_ff     <= '0;
         misses_ff    <= '0;
         capacity_ff  <= CAPACITY_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         scan_idx_ff  <= scan_idx_in;
         pend_ff      <= pend_in;
         found_ff     <= found_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         misses_ff    <= misses_in;
         capacity_ff  <= capacity_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pend_idx_ff    <= pend_idx_in;
      key_ff         <= key_in;
      ev_key_ff      <= ev_key_in;
      rsp_hit_ff     <= rsp_hit_in;
      rsp_evicted_ff <= rsp_evicted_in;
      rsp_ev_key_ff  <= rsp_ev_key_in;
      rsp_occ_ff     <= rsp_occ_in;
      rsp_misses_ff  <= rsp_misses_in;
   end

   // key memory: registered read, data valid in the cycle after the address
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= key_mem[rd_addr];
      end
      if (wr_en) begin
         key_mem[wr_addr] <= wr_data;
      end
   end

   `LCMC_ASSERT_NOW(a_count_bound, 1'b1, 32'(count_ff) <= DEPTH, "occupancy above depth")
   `LCMC_ASSERT_NEXT(a_misses_monotonic, 1'b1, misses_ff >= $past(misses_ff), "miss count fell")
   `LCMC_ASSERT_NOW(a_evict_is_miss, rsp_valid_ff && rsp_evicted_ff, !rsp_hit_ff, "evict on hit")
   `LCMC_ASSERT_NOW(a_hit_has_entry, (state_ff == ST_FINISH) && found_ff, count_ff != '0, "hit in empty cache")
   `LCMC_ASSERT_NOW(a_read_in_range, rd_en, scan_idx_ff < count_ff, "scan read past occupancy")

endmodule

@@ test/lru_cache_miss_counter_unit_checker.sv @@
module lru_cache_miss_counter_unit_checker #(
   parameter int DEPTH = lcmc_pkg::LCMC_DEPTH
) (
   input  logic                                         clock,
   input  logic                                         reset,
   input  logic                                         req_valid,
   input  logic                                         req_ready,
   input  logic signed [lcmc_pkg::ACCESS_KEY_WIDTH-1:0] req_access_key,
   input  logic                                         rsp_valid,
   input  logic                                         rsp_ready,
   input  logic                                         rsp_hit,
   input  logic                                         rsp_evicted,
   input  logic signed [lcmc_pkg::ACCESS_KEY_WIDTH-1:0] rsp_evicted_key,
   input  logic [lcmc_pkg::OCCUPANCY_WIDTH-1:0]         rsp_occupancy,
   input  logic [lcmc_pkg::MISS_COUNT_WIDTH-1:0]        rsp_miss_count,
   input  logic                                         csr_wr_en,
   input  logic [lcmc_pkg::CAPACITY_WIDTH-1:0]          csr_wr_data,
   output int                                           pending,
   output int                                           mismatches
);
   import lcmc_pkg::*;

   typedef struct packed {
      logic                               hit;
      logic                               evicted;
      logic signed [ACCESS_KEY_WIDTH-1:0] evicted_key;
      logic [OCCUPANCY_WIDTH-1:0]         occupancy;
      logic [MISS_COUNT_WIDTH-1:0]        miss_count;
   } lru_result_type;

   // resident keys, index 0 least recent
   logic [ACCESS_KEY_WIDTH-1:0] resident_keys [DEPTH];
   int unsigned                 resident_count = 0;
   logic [MISS_COUNT_WIDTH-1:0] miss_total = '0;
   logic [CAPACITY_WIDTH-1:0]   capacity_reg = CAPACITY_RESET;
   lru_result_type              awaited_results [$];
   int                          errors = 0;

   // close the gap toward the least-recent end
   function automatic void drop_entry(input int unsigned pos);
      for (int unsigned i = pos; i + 1 < resident_count; i++)
         resident_keys[i] = resident_keys[i + 1];
      if (resident_count > 0)
         resident_count--;
   endfunction

   function automatic lru_result_type lru_access(input logic [ACCESS_KEY_WIDTH-1:0] key);
      lru_result_type res;
      int unsigned    limit;
      int unsigned    pos;
      bit             found;
      res   = '0;
      limit = capacity_reg;
      if (limit == 0)
         limit = 1;
      if (limit > DEPTH)
         limit = DEPTH;
      found = 0;
      pos   = 0;
      for (int unsigned i = 0; i < resident_count; i++)
         if (!found && resident_keys[i] == key) begin
            found = 1;
            pos   = i;
         end
      if (found) begin
         drop_entry(pos);
      end else begin
         if (resident_count >= limit) begin
            res.evicted     = 1'b1;
            res.evicted_key = resident_keys[0];
            drop_entry(0);
         end
         if (miss_total != MISS_MAX)
            miss_total++;
      end
      if (resident_count < DEPTH) begin
         resident_keys[resident_count] = key;
         resident_count++;
      end
      res.hit        = found;
      res.occupancy  = OCCUPANCY_WIDTH'(resident_count);
      res.miss_count = miss_total;
      return res;
   endfunction

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected 0x%h, got 0x%h", name, want, got);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      lru_result_type want;
      if (reset) begin
         resident_count = 0;
         miss_total     = '0;
         capacity_reg   = CAPACITY_RESET;
         awaited_results.delete();
      end else begin
         if (csr_wr_en)
            capacity_reg = csr_wr_data;
         if (rsp_valid && rsp_ready) begin
            if (awaited_results.size() == 0) begin
               $error("result item arrived with no access outstanding");
               errors++;
            end else begin
               want = awaited_results.pop_front();
               check_field("hit", 32'(want.hit), 32'(rsp_hit));
               check_field("evicted", 32'(want.evicted), 32'(rsp_evicted));
               check_field("evicted_key", want.evicted_key, rsp_evicted_key);
               check_field("occupancy", 32'(want.occupancy), 32'(rsp_occupancy));
               check_field("miss_count", want.miss_count, rsp_miss_count);
            end
         end
         if (req_valid && req_ready)
            awaited_results.push_back(lru_access(req_access_key));
      end
      pending    <= awaited_results.size();
      mismatches <= errors;
   end

endmodule

@@ test/lru_cache_miss_counter_unit_tb.sv @@
module lru_cache_miss_counter_unit_tb;
   import lcmc_pkg::*;

   // Slowest item: 16 resident entries scanned, plus the longest gaps on both sides.
   localparam int CYCLE_LIMIT  = 500000;
   // Wait after the last burst for any late result item, with a margin.
   localparam int DRAIN_CYCLES = LCMC_DEPTH + 8;
   localparam int PHASES       = 8;
   localparam int PHASE_ITEMS  = 100;
   // Capacity per random phase; the last one is drawn at run time.
   localparam int PHASE_CAPACITY [PHASES] = '{16, 1, 4, 0, 31, 9, 2, 16};

   logic                        clock;
   logic                        reset;
   logic                        csr_wr_en;
   logic [CAPACITY_WIDTH-1:0]   csr_wr_data;
   int                          pending;
   int                          mismatches;
   int                          cycles = 0;
   int                          items_sent = 0;
   int                          settings_used = 0;
   bit                          calm = 0;
   logic [ACCESS_KEY_WIDTH-1:0] key_pool [$];

   lcmc_req_if req_ch ();
   lcmc_rsp_if rsp_ch ();

   lru_cache_miss_counter_unit i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // Watch both channels and the register port; predict and compare each result item.
   lru_cache_miss_counter_unit_checker i_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_ch.valid),
      .req_ready       (req_ch.ready),
      .req_access_key  (req_ch.access_key),
      .rsp_valid       (rsp_ch.valid),
      .rsp_ready       (rsp_ch.ready),
      .rsp_hit         (rsp_ch.hit),
      .rsp_evicted     (rsp_ch.evicted),
      .rsp_evicted_key (rsp_ch.evicted_key),
      .rsp_occupancy   (rsp_ch.occupancy),
      .rsp_miss_count  (rsp_ch.miss_count),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .pending         (pending),
      .mismatches      (mismatches)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Stop a hung run: count every cycle and give up at the limit.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("lru_cache_miss_counter_unit_tb: FAIL");
         $finish;
      end
   end

   // Idle length: mostly none or a few cycles, now and then a long one.
   // In a calm phase hold the channel busy throughout.
   function automatic int idle_length();
      int roll;
      roll = $urandom_range(0, 99);
      if (calm || roll < 50)
         return 0;
      if (roll < 90)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Offer one access item and hold it until the block takes it.
   // Valid stays high after acceptance so back-to-back items need no second assignment.
   task automatic send_access(input logic [ACCESS_KEY_WIDTH-1:0] key);
      int gap;
      gap = idle_length();
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid      <= 1'b1;
      req_ch.access_key <= key;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      items_sent++;
   endtask

   // Drop valid and wait until every outstanding result item has been taken.
   task automatic close_burst();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   // Write the capacity register; only called with the block idle.
   task automatic set_capacity(input logic [CAPACITY_WIDTH-1:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      settings_used++;
   endtask

   // Build a fresh pool of full-width random keys so that hits recur.
   task automatic fill_pool(input int count);
      key_pool.delete();
      repeat (count) key_pool.push_back($urandom);
   endtask

   // Mostly reuse pool keys (hits, reorders, evictions); sometimes a stray key.
   function automatic logic [ACCESS_KEY_WIDTH-1:0] pool_key();
      if (key_pool.size() > 0 && $urandom_range(0, 99) < 85)
         return key_pool[$urandom_range(0, key_pool.size() - 1)];
      return $urandom;
   endfunction

   // Result side: accept in stretches, stall between them.
   initial begin
      int run;
      int gap;
      rsp_ch.ready <= 1'b0;
      wait (reset === 1'b0);
      forever begin
         run = $urandom_range(1, 12);
         rsp_ch.ready <= 1'b1;
         repeat (run) @(posedge clock);
         gap = idle_length();
         if (gap > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   end

   initial begin
      int cap;
      reset             <= 1'b1;
      req_ch.valid      <= 1'b0;
      req_ch.access_key <= '0;
      csr_wr_en         <= 1'b0;
      csr_wr_data       <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Key extremes at the reset capacity; repeat two of them to force hits.
      send_access(32'h8000_0000);
      send_access(32'h7FFF_FFFF);
      send_access(32'h0000_0000);
      send_access(32'hFFFF_FFFF);
      send_access(32'h8000_0000);
      send_access(32'hAAAA_AAAA);
      send_access(32'h5555_5555);
      send_access(32'h0000_0000);
      close_burst();

      // Lower capacity below occupancy: a miss evicts one and occupancy holds.
      set_capacity(2);
      send_access(32'h1234_5678);
      send_access(32'h5555_5555);
      close_burst();

      // Capacity zero behaves as one.
      set_capacity(0);
      send_access(32'h0000_0001);
      send_access(32'h0000_0001);
      close_burst();

      // Capacity above the depth behaves as the depth; fill the cache to the top.
      set_capacity(31);
      for (int i = 0; i < 10; i++)
         send_access(32'h0F0F_0000 + i);
      close_burst();

      // Full cache under capacity one: each miss evicts and occupancy stays full.
      set_capacity(1);
      send_access(32'hFFFF_0000);
      send_access(32'hFFFF_0000);
      close_burst();

      // Random phases, each with its own capacity and key pool.
      for (int p = 0; p < PHASES; p++) begin
         cap = PHASE_CAPACITY[p];
         if (p == PHASES - 1)
            cap = $urandom_range(0, 31);
         set_capacity(CAPACITY_WIDTH'(cap));
         calm = (p % 3 == 2);
         fill_pool($urandom_range(1, 28));
         repeat (PHASE_ITEMS) send_access(pool_key());
         close_burst();
      end
      calm = 0;

      // Let any stray result item show up before the verdict.
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Covered %0d accesses over %0d capacity writes (0, 1, 16 and 31 among them)",
               items_sent, settings_used);
      $display("Mismatches found: %0d", mismatches);
      if (mismatches == 0)
         $display("lru_cache_miss_counter_unit_tb: PASS");
      else
         $display("lru_cache_miss_counter_unit_tb: FAIL");
      $finish;
   end

endmodule
